// File: src/fcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

    // payload widths
    localparam int CODE_W = 8;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 10;

    // configuration port
    localparam int CFG_W  = 11;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // default grid limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // register reset values
    localparam logic [CFG_W-1:0]  RST_GRID_WIDTH  = 11'd1024;
    localparam logic [CFG_W-1:0]  RST_GRID_HEIGHT = 11'd1024;
    localparam logic [CODE_W-1:0] RST_UNOBS_CODE  = 8'd0;
    localparam logic [CODE_W-1:0] RST_OBS_CODE    = 8'd1;

    // smallest usable grid side
    localparam int MIN_SIDE = 3;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_UNOBS_CODE  = 2'd2,
        REG_OBS_CODE    = 2'd3
    } t_reg_idx;

endpackage

`default_nettype wire

// File: src/fcd_intf.sv
`timescale 1ns / 1ps
`default_nettype none

interface fcd_cell_if
    import fcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] cell_code;

    modport source (output valid, output cell_code, input ready);
    modport sink   (input valid, input cell_code, output ready);
endinterface

interface fcd_result_if
    import fcd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
    logic             is_frontier;
    logic             last_of_frame;

    modport source (output valid, output center_row, output center_col,
                    output is_frontier, output last_of_frame, input ready);
    modport sink   (input valid, input center_row, input center_col,
                    input is_frontier, input last_of_frame, output ready);
endinterface

`default_nettype wire

// File: src/frontier_cell_detector_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// an accepted cell passes through stage 1, then its result (if any) is held in the result register
// throughput: one cell per clock, held back only when the result register is stalled
// the pace is set by the single-read row memories and the one result register
// reset (synchronous, active low) clears counters, window, valid flags and configuration registers
// row memories are not cleared; each entry is written before it is read in a frame
module frontier_cell_detector_unit
    import fcd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    fcd_cell_if.sink               i_cell,
    fcd_result_if.source           o_result,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    // column and row counter widths, and widths that also hold the sizes themselves
    localparam int CNT_CW = $clog2(MAX_WIDTH);
    localparam int CNT_RW = $clog2(MAX_HEIGHT);
    localparam int SZ_CW  = CNT_CW + 1;
    localparam int SZ_RW  = CNT_RW + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  r_grid_width;
    logic [CFG_W-1:0]  r_grid_height;
    logic [CODE_W-1:0] r_unobs_code;
    logic [CODE_W-1:0] r_obs_code;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= RST_GRID_WIDTH;
            r_grid_height <= RST_GRID_HEIGHT;
            r_unobs_code  <= RST_UNOBS_CODE;
            r_obs_code    <= RST_OBS_CODE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[CFG_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[CFG_W-1:0];
                REG_UNOBS_CODE:  r_unobs_code  <= pwdata[CODE_W-1:0];
                REG_OBS_CODE:    r_obs_code    <= pwdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GRID_WIDTH:  prdata = APB_DW'(r_grid_width);
            REG_GRID_HEIGHT: prdata = APB_DW'(r_grid_height);
            REG_UNOBS_CODE:  prdata = APB_DW'(r_unobs_code);
            REG_OBS_CODE:    prdata = APB_DW'(r_obs_code);
            default:         prdata = '0;
        endcase
    end

    // sizes in use, clamped to the legal range of this build
    logic [SZ_CW-1:0] w_eff;
    logic [SZ_RW-1:0] h_eff;

    always_comb begin
        if (32'(r_grid_width) < 32'(MIN_SIDE)) begin
            w_eff = SZ_CW'(MIN_SIDE);
        end else if (32'(r_grid_width) > 32'(MAX_WIDTH)) begin
            w_eff = SZ_CW'(MAX_WIDTH);
        end else begin
            w_eff = SZ_CW'(r_grid_width);
        end
        if (32'(r_grid_height) < 32'(MIN_SIDE)) begin
            h_eff = SZ_RW'(MIN_SIDE);
        end else if (32'(r_grid_height) > 32'(MAX_HEIGHT)) begin
            h_eff = SZ_RW'(MAX_HEIGHT);
        end else begin
            h_eff = SZ_RW'(r_grid_height);
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // stage 1 holds the accepted cell while the row memories return data;
    // the result register sits behind it
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    logic [CNT_CW-1:0] r_s1_col;
    logic [CNT_RW-1:0] r_s1_row;
    logic [CODE_W-1:0] r_s1_cell;
    logic              s1_has_res;
    logic              s1_adv;
    logic              in_acc;

    logic              r_o_valid;

    assign s1_adv       = r_s1_valid & (~s1_has_res | ~r_o_valid | o_result.ready);
    assign i_cell.ready = ~r_s1_valid | s1_adv;
    assign in_acc       = i_cell.valid & i_cell.ready;

    // ------------------------------------------------------------------
    // raster counters
    // ------------------------------------------------------------------
    logic [CNT_CW-1:0] r_col;
    logic [CNT_RW-1:0] r_row;
    logic [SZ_CW-1:0]  col_inc;
    logic [SZ_RW-1:0]  row_inc;

    assign col_inc = {1'b0, r_col} + 1'b1;
    assign row_inc = {1'b0, r_row} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (col_inc >= w_eff) begin
                // end of row; wrap to a new frame after the last row
                r_col <= '0;
                r_row <= (row_inc >= h_eff) ? '0 : row_inc[CNT_RW-1:0];
            end else begin
                r_col <= col_inc[CNT_CW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // row memories
    // the row above is kept twice so that columns c and c+1 read together;
    // the row two above is refreshed from the centre word as stage 1 retires
    // ------------------------------------------------------------------
    logic [CODE_W-1:0] prev_ctr;
    logic [CODE_W-1:0] prev_rgt;
    logic [CODE_W-1:0] older_up;

    fcd_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_WIDTH)
    ) u_prev_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_col),
        .i_wdata (i_cell.cell_code),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (prev_ctr)
    );

    fcd_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_WIDTH)
    ) u_prev_rgt_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_col),
        .i_wdata (i_cell.cell_code),
        .i_re    (in_acc),
        .i_raddr (col_inc[CNT_CW-1:0]),
        .o_rdata (prev_rgt)
    );

    fcd_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (prev_ctr),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (older_up)
    );

    // ------------------------------------------------------------------
    // stage 1: accepted cell and its position
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_cell <= i_cell.cell_code;
        end
    end

    // left neighbour: centre word of the previous step, slid along the window
    logic [CODE_W-1:0] r_win_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left <= '0;
        end else if (s1_adv) begin
            r_win_left <= prev_ctr;
        end
    end

    // ------------------------------------------------------------------
    // frontier test on the cell one row above the incoming one
    // ------------------------------------------------------------------
    logic [SZ_CW-1:0] s1_col_inc;
    logic [SZ_CW-1:0] s1_col_inc2;
    logic [SZ_RW-1:0] s1_row_inc;
    logic             s1_interior;
    logic             s1_obs_near;
    logic             s1_frontier;
    logic             s1_last;

    assign s1_col_inc  = {1'b0, r_s1_col} + 1'b1;
    assign s1_col_inc2 = {1'b0, r_s1_col} + SZ_CW'(2);
    assign s1_row_inc  = {1'b0, r_s1_row} + 1'b1;

    assign s1_interior = ({1'b0, r_s1_row} >= SZ_RW'(2)) &&
                         ({1'b0, r_s1_row} <  h_eff) &&
                         (r_s1_col != '0) &&
                         (s1_col_inc < w_eff);
    assign s1_has_res  = s1_interior;

    assign s1_obs_near = (r_win_left == r_obs_code) || (prev_rgt == r_obs_code) ||
                         (older_up == r_obs_code)   || (r_s1_cell == r_obs_code);
    assign s1_frontier = (prev_ctr == r_unobs_code) && s1_obs_near;
    assign s1_last     = (s1_row_inc == h_eff) && (s1_col_inc2 == w_eff);

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] r_o_row;
    logic [COL_W-1:0] r_o_col;
    logic             r_o_frontier;
    logic             r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv && s1_has_res) begin
            r_o_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_has_res) begin
            r_o_row      <= ROW_W'(r_s1_row - 1'b1);
            r_o_col      <= COL_W'(r_s1_col);
            r_o_frontier <= s1_frontier;
            r_o_last     <= s1_last;
        end
    end

    assign o_result.valid         = r_o_valid;
    assign o_result.center_row    = r_o_row;
    assign o_result.center_col    = r_o_col;
    assign o_result.is_frontier   = r_o_frontier;
    assign o_result.last_of_frame = r_o_last;

endmodule

`default_nettype wire

// File: src/fcd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fcd_ram
    import fcd_pkg::*;
#(
    parameter int WIDTH = CODE_W,
    parameter int DEPTH = DEF_MAX_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
